// ===== hdl/dfse_pkg.sv =====
package dfse_pkg;

	// Motor channels served; motor_index is one bit wide
	localparam int MOTOR_COUNT = 2;

	// Frames that may wait between the scheduler and the serialiser
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Pulses in one frame, sent most significant bit first
	localparam int PULSES = 16;
	localparam int CNT_W  = $clog2(PULSES);

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_SHORT_PULSE = 3'd0;
	localparam logic [2:0] REG_LONG_PULSE  = 3'd1;
	localparam logic [2:0] REG_MIN_GAP     = 3'd2;
	localparam logic [2:0] REG_REPEAT_GAP  = 3'd3;
	localparam logic [2:0] REG_TELEM_GAP   = 3'd4;

	localparam logic [14:0] SHORT_PULSE_RESET = 15'd44;
	localparam logic [14:0] LONG_PULSE_RESET  = 15'd89;
	localparam logic [23:0] MIN_GAP_RESET     = 24'd50;
	localparam logic [23:0] REPEAT_GAP_RESET  = 24'd5000;
	localparam logic [23:0] TELEM_GAP_RESET   = 24'd25000;

	// Throttle code ranges
	localparam logic [10:0] FWD_BASE = 11'd47;
	localparam logic [10:0] FWD_MAX  = 11'd1047;
	localparam logic [10:0] REV_BASE = 11'd1048;
	localparam logic [10:0] REV_MAX  = 11'd2047;

	// Request kinds
	localparam logic REQ_THROTTLE = 1'b0;
	localparam logic REQ_COMMAND  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic               motor_index;
		logic signed [11:0] speed;
		logic [10:0]        command_code;
		logic [31:0]        now_us;
	} req_t;

	typedef struct packed {
		logic        out_motor;
		logic [14:0] high_ticks;
		logic [14:0] low_ticks;
		logic        bit_value;
		logic        telemetry_request;
		logic [15:0] frame_word;
		logic        last_pulse;
	} pulse_t;

	typedef struct packed {
		logic [14:0] short_pulse_ticks;
		logic [14:0] long_pulse_ticks;
		logic [23:0] min_gap_us;
		logic [23:0] repeat_gap_us;
		logic [23:0] telemetry_gap_us;
	} cfg_t;

	typedef struct packed {
		logic        motor;
		logic [15:0] word;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== hdl/dfse_regs.sv =====
module dfse_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dfse_pkg::ADDR_W-1:0] paddr,
	input  logic [dfse_pkg::DATA_W-1:0] pwdata,
	output logic [dfse_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output dfse_pkg::cfg_t              cfg
);

	dfse_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_pulse_ticks <= dfse_pkg::SHORT_PULSE_RESET;
			cfg_q.long_pulse_ticks  <= dfse_pkg::LONG_PULSE_RESET;
			cfg_q.min_gap_us        <= dfse_pkg::MIN_GAP_RESET;
			cfg_q.repeat_gap_us     <= dfse_pkg::REPEAT_GAP_RESET;
			cfg_q.telemetry_gap_us  <= dfse_pkg::TELEM_GAP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				dfse_pkg::REG_SHORT_PULSE: cfg_q.short_pulse_ticks <= pwdata[14:0];
				dfse_pkg::REG_LONG_PULSE:  cfg_q.long_pulse_ticks  <= pwdata[14:0];
				dfse_pkg::REG_MIN_GAP:     cfg_q.min_gap_us        <= pwdata[23:0];
				dfse_pkg::REG_REPEAT_GAP:  cfg_q.repeat_gap_us     <= pwdata[23:0];
				dfse_pkg::REG_TELEM_GAP:   cfg_q.telemetry_gap_us  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			dfse_pkg::REG_SHORT_PULSE: prdata = {17'd0, cfg_q.short_pulse_ticks};
			dfse_pkg::REG_LONG_PULSE:  prdata = {17'd0, cfg_q.long_pulse_ticks};
			dfse_pkg::REG_MIN_GAP:     prdata = {8'd0, cfg_q.min_gap_us};
			dfse_pkg::REG_REPEAT_GAP:  prdata = {8'd0, cfg_q.repeat_gap_us};
			dfse_pkg::REG_TELEM_GAP:   prdata = {8'd0, cfg_q.telemetry_gap_us};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== hdl/dfse_front.sv =====
module dfse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  dfse_pkg::cfg_t    cfg,
	input  logic              req_valid,
	output logic              req_ready,
	input  dfse_pkg::req_t    req_data,
	input  dfse_pkg::qstat_t  qstat,
	output logic              push,
	output dfse_pkg::frame_t  push_data
);

	// Signed speed to eleven-bit throttle code, saturating in both directions.
	function automatic logic [10:0] throttle_code(input logic [11:0] sp);
		logic [11:0] mag;
		logic [12:0] fwd;
		logic [12:0] rev;
		logic [10:0] code;
		mag = 12'd0 - sp;
		fwd = 13'(dfse_pkg::FWD_BASE) + {1'b0, sp};
		rev = 13'(dfse_pkg::REV_BASE) + {1'b0, mag};
		if (sp == 12'd0) begin
			code = 11'd0;
		end else if (!sp[11]) begin
			code = (fwd > 13'(dfse_pkg::FWD_MAX)) ? dfse_pkg::FWD_MAX : fwd[10:0];
		end else begin
			code = (rev > 13'(dfse_pkg::REV_MAX)) ? dfse_pkg::REV_MAX : rev[10:0];
		end
		return code;
	endfunction

	logic [11:0] prev_speed_q     [dfse_pkg::MOTOR_COUNT];
	logic [31:0] prev_send_time_q [dfse_pkg::MOTOR_COUNT];
	logic [31:0] telemetry_time_q;

	logic        accept;
	logic        motor_ok;
	logic        is_cmd;
	logic [31:0] interval;
	logic [31:0] telem_elapsed;
	logic        too_soon;
	logic        resend;
	logic        send_thr;
	logic        telem_due;
	logic        upd_thr;
	logic [11:0] top12;
	logic [3:0]  csum;

	assign req_ready = ~qstat.full;
	assign accept    = req_valid & req_ready;
	assign motor_ok  = {31'd0, req_data.motor_index} < 32'(dfse_pkg::MOTOR_COUNT);
	assign is_cmd    = req_data.req_type == dfse_pkg::REQ_COMMAND;

	assign interval      = req_data.now_us - prev_send_time_q[req_data.motor_index];
	assign telem_elapsed = req_data.now_us - telemetry_time_q;
	assign too_soon      = interval < {8'd0, cfg.min_gap_us};
	assign resend        = (interval > {8'd0, cfg.repeat_gap_us}) ||
	                       (req_data.speed != prev_speed_q[req_data.motor_index]);
	assign send_thr      = ~too_soon & resend;
	assign telem_due     = telem_elapsed > {8'd0, cfg.telemetry_gap_us};
	assign upd_thr       = accept & motor_ok & ~is_cmd & send_thr;

	assign top12 = is_cmd ? {req_data.command_code, 1'b1}
	                      : {throttle_code(req_data.speed), telem_due};
	assign csum  = top12[3:0] ^ top12[7:4] ^ top12[11:8];

	assign push            = accept & motor_ok & (is_cmd | send_thr);
	assign push_data.motor = req_data.motor_index;
	assign push_data.word  = {top12, csum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dfse_pkg::MOTOR_COUNT; i++) begin
				prev_speed_q[i]     <= '0;
				prev_send_time_q[i] <= '0;
			end
			telemetry_time_q <= '0;
		end else if (upd_thr) begin
			prev_speed_q[req_data.motor_index]     <= req_data.speed;
			prev_send_time_q[req_data.motor_index] <= req_data.now_us;
			if (telem_due) begin
				telemetry_time_q <= req_data.now_us;
			end
		end
	end

endmodule

// ===== hdl/dfse_queue.sv =====
module dfse_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dfse_pkg::frame_t  push_data,
	input  logic              pop,
	output dfse_pkg::frame_t  pop_data,
	output dfse_pkg::qstat_t  qstat
);

	dfse_pkg::frame_t              slot_q [dfse_pkg::QUEUE_DEPTH];
	logic [dfse_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [dfse_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [dfse_pkg::QCNT_W-1:0]   count_q;

	function automatic logic [dfse_pkg::QPTR_W-1:0] next_ptr(
		input logic [dfse_pkg::QPTR_W-1:0] p
	);
		logic [dfse_pkg::QPTR_W-1:0] n;
		if (p == dfse_pkg::QPTR_W'(dfse_pkg::QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	assign qstat.full  = count_q == dfse_pkg::QCNT_W'(dfse_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_data    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/dfse_back.sv =====
module dfse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dfse_pkg::cfg_t    cfg,
	input  dfse_pkg::qstat_t  qstat,
	input  dfse_pkg::frame_t  pop_data,
	output logic              pop,
	output logic              pulse_valid,
	input  logic              pulse_ready,
	output dfse_pkg::pulse_t  pulse_data
);

	logic                       busy_q;
	logic [dfse_pkg::CNT_W-1:0] cnt_q;
	dfse_pkg::frame_t           cur_q;

	logic last;
	logic taken;
	logic done;
	logic load;
	logic bit_v;

	assign last  = cnt_q == dfse_pkg::CNT_W'(dfse_pkg::PULSES - 1);
	assign taken = busy_q & pulse_ready;
	assign done  = taken & last;
	// A waiting frame is picked up in the cycle its predecessor's last beat leaves.
	assign load  = (~busy_q | done) & ~qstat.empty;
	assign pop   = load;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (taken) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign bit_v       = cur_q.word[~cnt_q];
	assign pulse_valid = busy_q;

	assign pulse_data.out_motor         = cur_q.motor;
	assign pulse_data.high_ticks        = bit_v ? cfg.long_pulse_ticks : cfg.short_pulse_ticks;
	assign pulse_data.low_ticks         = bit_v ? cfg.short_pulse_ticks : cfg.long_pulse_ticks;
	assign pulse_data.bit_value         = bit_v;
	assign pulse_data.telemetry_request = cur_q.word[4];
	assign pulse_data.frame_word        = cur_q.word;
	assign pulse_data.last_pulse        = last;

endmodule

// ===== hdl/dshot_frame_scheduler_encoder.sv =====
// Frame scheduler and pulse encoder for a two-channel digital motor link. Each request beat is
// either a throttle update or a raw command for one motor; throttle updates obey a per-motor
// minimum gap and are sent only when the speed changes or the repeat interval has run out,
// while raw commands always go out with the telemetry bit set. Every frame that is sent leaves
// as sixteen pulse beats, most significant bit first, each carrying its high and low tick
// counts. A request beat is accepted in any cycle in which the two-entry frame queue has room,
// and the decision for it is made in that same cycle; the frame is written into the queue and
// then loaded into the serialiser, whose registered state offers its first pulse beat once the
// serialiser is free. The serialiser emits one pulse beat per cycle while pulse_ready is high,
// and a waiting frame follows the last beat of the previous one back to back.
module dshot_frame_scheduler_encoder (
	input  logic                        clk,
	input  logic                        arst_n,

	// Request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  dfse_pkg::req_t              req_data,

	// Pulse channel
	output logic                        pulse_valid,
	input  logic                        pulse_ready,
	output dfse_pkg::pulse_t            pulse_data,

	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dfse_pkg::ADDR_W-1:0] paddr,
	input  logic [dfse_pkg::DATA_W-1:0] pwdata,
	output logic [dfse_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	// Register file shared by the scheduler (timing limits) and the serialiser (pulse widths).
	dfse_pkg::cfg_t   cfg;

	// Frames travel from the scheduler to the serialiser through a short queue, so that a new
	// request can be judged while the previous frame is still being shifted out.
	logic             push;
	dfse_pkg::frame_t push_data;
	logic             pop;
	dfse_pkg::frame_t pop_data;
	dfse_pkg::qstat_t qstat;

	dfse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The scheduler holds the per-motor history and the shared telemetry timer, and builds the
	// complete sixteen-bit frame with its checksum.
	dfse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	dfse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// The serialiser keeps the current frame and a bit counter; its outputs come straight from those
	// registers and the configuration, so a stalled pulse beat holds steady while cfg is unchanged.
	dfse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.qstat       (qstat),
		.pop_data    (pop_data),
		.pop         (pop),
		.pulse_valid (pulse_valid),
		.pulse_ready (pulse_ready),
		.pulse_data  (pulse_data)
	);

endmodule
